[hdl/etfp_pkg.sv]
// Shared types and constants for the escape-time fractal pixel engine.
// Holds the request and response payload structs, the register indexes,
// the sequencer states and the fixed-point helper functions. No dependencies.
package etfp_pkg;

   // Input request: one pixel position.
   typedef struct packed {
      logic [9:0] pixel_col;
      logic [9:0] pixel_row;
   } req_type;

   // Response: the echoed position, the iteration count and the color.
   typedef struct packed {
      logic [9:0]  out_col;
      logic [9:0]  out_row;
      logic [8:0]  iteration_count;
      logic [23:0] pixel_color;
   } rsp_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_FRACTAL_MODE = 3'd0;
   localparam logic [2:0] CSR_STEP_REAL    = 3'd1;
   localparam logic [2:0] CSR_STEP_IMAG    = 3'd2;
   localparam logic [2:0] CSR_CENTER_REAL  = 3'd3;
   localparam logic [2:0] CSR_CENTER_IMAG  = 3'd4;
   localparam logic [2:0] CSR_JULIA_REAL   = 3'd5;
   localparam logic [2:0] CSR_JULIA_IMAG   = 3'd6;

   // Register reset values.
   localparam logic [30:0] STEP_RESET = 31'd2097152;

   // Fractal modes.
   localparam logic MODE_MANDELBROT = 1'b0;

   // Escape bound 4.0 in Q8.56.
   localparam logic [64:0] ESCAPE_BOUND = 65'h0_0400_0000_0000_0000;

   // Palette rotation by 0.1 rad, Q2.30.
   localparam logic signed [31:0] ROT_COS  = 32'sd1068377587;
   localparam logic signed [31:0] ROT_SIN  = 32'sd107195315;
   localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;
   localparam logic signed [63:0] Q30_HALF = 64'sd536870912;

   // Fixed colors.
   localparam logic [23:0] COLOR_BLACK = 24'h000000;
   localparam logic [23:0] COLOR_GRAY  = 24'h808080;

   // Saturation bounds for Q4.28 results.
   localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

   // Sequencer states, one-hot.
   typedef enum logic [13:0] {
      ST_IDLE = 14'b00000000000001,
      ST_MAPR = 14'b00000000000010,
      ST_MAPI = 14'b00000000000100,
      ST_INIT = 14'b00000000001000,
      ST_IT1  = 14'b00000000010000,
      ST_IT2  = 14'b00000000100000,
      ST_IT3  = 14'b00000001000000,
      ST_PAL1 = 14'b00000010000000,
      ST_PAL2 = 14'b00000100000000,
      ST_PAL3 = 14'b00001000000000,
      ST_PAL4 = 14'b00010000000000,
      ST_PAL5 = 14'b00100000000000,
      ST_PFIN = 14'b01000000000000,
      ST_DONE = 14'b10000000000000
   } state_type;

   // Clamp a wide signed value into 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[31:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Add a Q4.28 offset to an already shifted product and saturate.
   function automatic logic signed [31:0] add_sat(input logic signed [63:0] v,
                                                  input logic signed [31:0] ofs);
      logic signed [63:0] ofs_ext;
      ofs_ext = ofs;
      return sat32(v + ofs_ext);
   endfunction

   // One palette channel: floor(s * 127 + 128) with s in Q30, clamped.
   function automatic logic [7:0] channel(input logic signed [31:0] s);
      logic signed [40:0] s_ext;
      logic signed [40:0] t;
      logic signed [40:0] v;
      logic [7:0]         r;
      s_ext = s;
      t = (s_ext <<< 7) - s_ext + 41'sh20_0000_0000;
      v = t >>> 30;
      if (v < 41'sd0) begin
         r = 8'd0;
      end else if (v > 41'sd255) begin
         r = 8'd255;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

[hdl/escape_time_fractal_pixel_top.sv]
// Escape-time fractal pixel engine, Mandelbrot or Julia, on one shared multiplier.
// Steps: mapping of the pixel into the plane, then the iterations, then for a pixel that
// escapes after n > 0 iterations the palette, made of 3*n rotations.
// One pixel at a time: the next request is taken in the cycle its response turns valid.
// Reset is synchronous and active high; it loads the register defaults.
module escape_time_fractal_pixel_top
   import etfp_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 1024,
   parameter int IMAGE_HEIGHT = 1024,
   parameter int ITER_LIMIT   = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int ITW = $clog2(ITER_LIMIT + 1);
   localparam logic [ITW-1:0] LIMIT_CNT = ITW'(ITER_LIMIT);
   localparam logic signed [31:0] WIDTH_S  = 32'(IMAGE_WIDTH);
   localparam logic signed [31:0] HEIGHT_S = 32'(IMAGE_HEIGHT);

   // Configuration registers.
   logic               mode_ff;
   logic [30:0]        step_real_ff;
   logic [30:0]        step_imag_ff;
   logic signed [31:0] center_real_ff;
   logic signed [31:0] center_imag_ff;
   logic signed [31:0] julia_real_ff;
   logic signed [31:0] julia_imag_ff;

   // Sequencer and working registers.
   state_type          state_ff, state_in;
   req_type            pix_ff, pix_in;
   logic signed [31:0] zr_ff, zr_in;
   logic signed [31:0] zi_ff, zi_in;
   logic signed [31:0] cr_ff, cr_in;
   logic signed [31:0] ci_ff, ci_in;
   logic signed [63:0] mul_ff, mul_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [ITW-1:0]     iter_ff, iter_in;
   logic               pend_ff, pend_in;
   logic signed [31:0] pc_ff, pc_in;
   logic signed [31:0] ps_ff, ps_in;
   logic [ITW-1:0]     rem_ff, rem_in;
   logic [1:0]         chan_ff, chan_in;
   logic               cap_ff, cap_in;
   logic [23:0]        color_ff, color_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Shared multiplier operands.
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] mul_prod;

   // Helpers.
   logic signed [31:0] d_col;
   logic signed [31:0] d_row;
   logic signed [31:0] point;
   logic [64:0]        mag;
   logic               escaped;
   logic signed [63:0] rr_diff;
   logic signed [63:0] rot_c_sum;
   logic signed [63:0] rot_s_sum;
   logic signed [63:0] rot_c_sh;
   logic signed [63:0] rot_s_sh;
   logic [ITW-1:0]     iter_inc;
   logic [ITW+8:0]     iter_wide;
   logic               rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_MANDELBROT;
         step_real_ff   <= STEP_RESET;
         step_imag_ff   <= STEP_RESET;
         center_real_ff <= '0;
         center_imag_ff <= '0;
         julia_real_ff  <= '0;
         julia_imag_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRACTAL_MODE: mode_ff        <= csr_wdata[0];
            CSR_STEP_REAL:    step_real_ff   <= csr_wdata[30:0];
            CSR_STEP_IMAG:    step_imag_ff   <= csr_wdata[30:0];
            CSR_CENTER_REAL:  center_real_ff <= csr_wdata;
            CSR_CENTER_IMAG:  center_imag_ff <= csr_wdata;
            CSR_JULIA_REAL:   julia_real_ff  <= csr_wdata;
            CSR_JULIA_IMAG:   julia_imag_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pixel offsets from the image center, doubled so they stay exact.
   assign d_col = $signed({21'b0, pix_ff.pixel_col, 1'b0}) - WIDTH_S;
   assign d_row = $signed({21'b0, pix_ff.pixel_row, 1'b0}) - HEIGHT_S;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = zr_ff;
      mul_b = zr_ff;
      unique case (state_ff)
         ST_MAPR: begin
            mul_a = d_col;
            mul_b = $signed({1'b0, step_real_ff});
         end
         ST_MAPI: begin
            mul_a = d_row;
            mul_b = $signed({1'b0, step_imag_ff});
         end
         ST_IT2: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         ST_IT3: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
         ST_PAL1: begin
            mul_a = pc_ff;
            mul_b = ROT_COS;
         end
         ST_PAL2: begin
            mul_a = ps_ff;
            mul_b = ROT_SIN;
         end
         ST_PAL3: begin
            mul_a = pc_ff;
            mul_b = ROT_SIN;
         end
         ST_PAL4: begin
            mul_a = ps_ff;
            mul_b = ROT_COS;
         end
         default: ;
      endcase
   end

   assign mul_prod = mul_a * mul_b;

   // Datapath terms read by the sequencer.
   assign point     = add_sat(mul_ff >>> 1, (state_ff == ST_MAPI) ? center_real_ff
                                                                  : center_imag_ff);
   assign mag       = {1'b0, acc_ff} + {1'b0, mul_ff};
   assign escaped   = (mag > ESCAPE_BOUND);
   assign rr_diff   = acc_ff - mul_ff;
   assign rot_c_sum = acc_ff - mul_ff + Q30_HALF;
   assign rot_s_sum = acc_ff + mul_ff + Q30_HALF;
   assign rot_c_sh  = rot_c_sum >>> 30;
   assign rot_s_sh  = rot_s_sum >>> 30;
   assign iter_inc  = iter_ff + 1'b1;
   assign iter_wide = {9'b0, iter_ff};

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      pix_in       = pix_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      mul_in       = mul_prod;
      acc_in       = acc_ff;
      iter_in      = iter_ff;
      pend_in      = pend_ff;
      pc_in        = pc_ff;
      ps_in        = ps_ff;
      rem_in       = rem_ff;
      chan_in      = chan_ff;
      cap_in       = cap_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pix_in   = req_data;
               state_in = ST_MAPR;
            end
         end
         ST_MAPR: begin
            state_in = ST_MAPI;
         end
         // Real coordinate is ready; Julia starts z there, Mandelbrot uses it as c.
         ST_MAPI: begin
            zr_in    = mode_ff ? point : '0;
            cr_in    = mode_ff ? julia_real_ff : point;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            zi_in    = mode_ff ? point : '0;
            ci_in    = mode_ff ? julia_imag_ff : point;
            iter_in  = '0;
            pend_in  = 1'b0;
            state_in = ST_IT1;
         end
         // Finish the imaginary update of the previous iteration from zr*zi.
         ST_IT1: begin
            if (pend_ff) begin
               zi_in = add_sat(mul_ff >>> 27, ci_ff);
            end
            state_in = ST_IT2;
         end
         ST_IT2: begin
            acc_in   = mul_ff;
            state_in = ST_IT3;
         end
         // Escape test on zr^2 + zi^2, then the real update.
         ST_IT3: begin
            if (escaped) begin
               if (iter_ff == '0) begin
                  color_in = COLOR_GRAY;
                  state_in = ST_DONE;
               end else begin
                  pc_in    = Q30_ONE;
                  ps_in    = '0;
                  rem_in   = iter_ff;
                  chan_in  = 2'd0;
                  cap_in   = 1'b0;
                  state_in = ST_PAL1;
               end
            end else begin
               zr_in   = add_sat(rr_diff >>> 28, cr_ff);
               iter_in = iter_inc;
               pend_in = 1'b1;
               if (iter_inc == LIMIT_CNT) begin
                  color_in = COLOR_BLACK;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_IT1;
               end
            end
         end
         // Palette rotation; a pending channel sample is taken from the sine.
         ST_PAL1: begin
            if (cap_ff) begin
               if (chan_ff == 2'd0) begin
                  color_in[23:16] = channel(ps_ff);
               end else begin
                  color_in[15:8] = channel(ps_ff);
               end
               chan_in = chan_ff + 2'd1;
               cap_in  = 1'b0;
            end
            state_in = ST_PAL2;
         end
         ST_PAL2: begin
            acc_in   = mul_ff;
            state_in = ST_PAL3;
         end
         ST_PAL3: begin
            pc_in    = rot_c_sh[31:0];
            state_in = ST_PAL4;
         end
         ST_PAL4: begin
            acc_in   = mul_ff;
            state_in = ST_PAL5;
         end
         ST_PAL5: begin
            ps_in = rot_s_sh[31:0];
            if (rem_ff == {{(ITW-1){1'b0}}, 1'b1}) begin
               rem_in   = iter_ff;
               cap_in   = 1'b1;
               state_in = (chan_ff == 2'd2) ? ST_PFIN : ST_PAL1;
            end else begin
               rem_in   = rem_ff - 1'b1;
               state_in = ST_PAL1;
            end
         end
         ST_PFIN: begin
            color_in[7:0] = channel(ps_ff);
            state_in      = ST_DONE;
         end
         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (rsp_free) begin
               rsp_data_in.out_col         = pix_ff.pixel_col;
               rsp_data_in.out_row         = pix_ff.pixel_row;
               rsp_data_in.iteration_count = iter_wide[8:0];
               rsp_data_in.pixel_color     = color_ff;
               rsp_valid_in                = 1'b1;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      mul_ff      <= mul_in;
      acc_ff      <= acc_in;
      iter_ff     <= iter_in;
      pend_ff     <= pend_in;
      pc_ff       <= pc_in;
      ps_ff       <= ps_in;
      rem_ff      <= rem_in;
      chan_ff     <= chan_in;
      cap_ff      <= cap_in;
      color_ff    <= color_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
